[hw/rtl/tssva_pkg.sv]
// ----------------------------------------------------------------------------
// Tone step sequencer package
// Shared widths, codes, state encoding and reset values for the three-voice
// square-wave effect sequencer.
// ----------------------------------------------------------------------------
package tssva_pkg;

  // Default structural parameters
  localparam int STEP_DEPTH_DEF  = 4096;
  localparam int VOICE_COUNT_DEF = 3;
  localparam int STEP_DEPTH_MIN  = 64;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 12;
  localparam int DIV_W    = 16;
  localparam int LEN_W    = 13;
  localparam int CHIP_W   = 4;
  localparam int VAL_W    = 8;
  localparam int PERIOD_W = 12;
  localparam int ACC_W    = 6;

  // Configuration port and register widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int INC_W      = 5;
  localparam int IV_W       = 5;
  localparam int VOL_W      = 4;

  // Divider to period conversion: (divider * 6866) >> 16, clamped
  localparam int                  SCALE_W      = 13;
  localparam logic [SCALE_W-1:0]  PERIOD_SCALE = 13'd6866;
  localparam int                  PROD_W       = DIV_W + SCALE_W;
  localparam int                  QUO_W        = PROD_W - 16;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 12'hFFF;

  // Address reduction: a 12-bit address over a store of at least 64 entries
  // has a quotient below 2^6, so six restoring steps give the remainder.
  localparam int MOD_STEPS = ADDR_W - $clog2(STEP_DEPTH_MIN);
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  // Step timing
  localparam logic [IV_W-1:0] MIN_INTERVAL = 5'd8;

  // Chip register map: volume registers start here
  localparam logic [CHIP_W-1:0] CHIP_VOL_BASE = 4'd8;

  // Configuration reset values
  localparam logic [INC_W-1:0] TICK_INC_RST = 5'd20;
  localparam logic [IV_W-1:0]  STEP_IV_RST  = 5'd11;
  localparam logic [VOL_W-1:0] VOLUME_RST   = 4'd12;

  // Input kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 2'd0,
    KIND_PLAY = 2'd1,
    KIND_TICK = 2'd2
  } kind_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_INC = 2'd0,
    CFG_STEP_IV  = 2'd1,
    CFG_VOLUME   = 2'd2
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_MOD,
    ST_LD_WR,
    ST_PL_MOD,
    ST_PL_REM,
    ST_PL_CMP,
    ST_PL_SET,
    ST_TK_SAT,
    ST_TK_CHK,
    ST_V_CHK,
    ST_V_DATA,
    ST_V_HI,
    ST_V_VOL,
    ST_TK_END
  } state_e;

endpackage

[hw/rtl/tone_step_sequencer_voice_alloc.sv]
// ----------------------------------------------------------------------------
// Tone step sequencer with voice allocation
// Three-voice square-wave effect sequencer: stores converted step periods,
// starts effects on free or stolen voices and, on each tick, steps the
// active voices and writes tone-chip period and volume registers.
//
//   channel   direction  handshake                  payload
//   command   in         start & !busy              kind, address, divider,
//                                                   effect_length
//   result    out        result_strobe_o (1 cycle)  chip_register, chip_value,
//                                                   last
//   config    in         cfg_we_i                   cfg_index_i, cfg_data_i
//
// Load runs six restoring steps of address reduction, then the store write.
// Play runs the reduction, then a remaining-steps compare per busy voice. A
// tick saturates the accumulator and adds the frame time, then runs up to
// four step rounds; each mutes ending voices and reads the store for live
// ones, writing a mute or period low, period high and volume. The single
// compare/subtract unit and the store read port serialize this work. Reset
// clears voices, accumulator and config to defaults; the store is not
// cleared. Results are never stalled; busy is high from the beat after a load,
// tick or nonzero-length play start until the item is finished.
// ----------------------------------------------------------------------------
module tone_step_sequencer_voice_alloc
  import tssva_pkg::*;
#(
  parameter int StepDepth  = STEP_DEPTH_DEF,
  parameter int VoiceCount = VOICE_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [ADDR_W-1:0]     address_i,
  input  logic [DIV_W-1:0]      divider_i,
  input  logic [LEN_W-1:0]      effect_length_i,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // result channel
  output logic                  result_strobe_o,
  output logic [CHIP_W-1:0]     chip_register_o,
  output logic [VAL_W-1:0]      chip_value_o,
  output logic                  last_o
);

  localparam int AW    = $clog2(StepDepth);
  localparam int VIdxW = (VoiceCount > 1) ? $clog2(VoiceCount) : 1;
  localparam int AluW  = (AW + MOD_STEPS > LEN_W) ? AW + MOD_STEPS : LEN_W;

  localparam logic [AluW-1:0]  DepthW  = AluW'(StepDepth);
  localparam logic [AluW-1:0]  DshInit = DepthW << (MOD_STEPS - 1);
  localparam logic [AW-1:0]    PtrLast = AW'(StepDepth - 1);
  localparam logic [VIdxW-1:0] VLast   = VIdxW'(VoiceCount - 1);

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [INC_W-1:0] inc_q;
  logic [IV_W-1:0]  step_iv_q;
  logic [VOL_W-1:0] vol_q;
  logic [IV_W-1:0]  iv;

  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [VIdxW-1:0]     v_q, v_d;
  logic [MOD_CNT_W-1:0] k_q, k_d;
  logic [AluW-1:0]      a_q, a_d;
  logic [AluW-1:0]      dsh_q, dsh_d;
  logic [DIV_W-1:0]     div_q, div_d;
  logic [LEN_W-1:0]     len_in_q, len_in_d;
  logic [LEN_W-1:0]     rem_q, rem_d;
  logic [LEN_W-1:0]     best_q, best_d;
  logic [VIdxW-1:0]     pick_q, pick_d;

  logic             act_q  [VoiceCount];
  logic             act_d  [VoiceCount];
  logic [LEN_W-1:0] vlen_q [VoiceCount];
  logic [LEN_W-1:0] vlen_d [VoiceCount];
  logic [LEN_W-1:0] vpos_q [VoiceCount];
  logic [LEN_W-1:0] vpos_d [VoiceCount];
  logic [AW-1:0]    vptr_q [VoiceCount];
  logic [AW-1:0]    vptr_d [VoiceCount];

  logic [AluW-1:0] alu_a, alu_b, alu_diff;
  logic            alu_ge;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [PERIOD_W-1:0] ram_rdata;
  logic [PERIOD_W-1:0] period;

  logic              emit_vld;
  logic [CHIP_W-1:0] emit_reg;
  logic [VAL_W-1:0]  emit_val;
  logic              tick_end;
  logic              vlast;

  logic              pend_vld_q, pend_vld_d;
  logic [CHIP_W-1:0] pend_reg_q, pend_reg_d;
  logic [VAL_W-1:0]  pend_val_q, pend_val_d;
  logic              out_vld_q, out_vld_d;
  logic              out_last_q, out_last_d;
  logic [CHIP_W-1:0] out_reg_q, out_reg_d;
  logic [VAL_W-1:0]  out_val_q, out_val_d;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q     <= TICK_INC_RST;
      step_iv_q <= STEP_IV_RST;
      vol_q     <= VOLUME_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TICK_INC: inc_q     <= cfg_data_i[INC_W-1:0];
        CFG_STEP_IV:  step_iv_q <= cfg_data_i[IV_W-1:0];
        CFG_VOLUME:   vol_q     <= cfg_data_i[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  // interval floor
  assign iv = (step_iv_q < MIN_INTERVAL) ? MIN_INTERVAL : step_iv_q;

  assign vlast = (v_q == VLast);
  assign busy  = (state_q != ST_IDLE);

  // --------------------------------------------------------------------------
  // Submodules
  // --------------------------------------------------------------------------
  tssva_alu #(
    .Width (AluW)
  ) u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .diff_o (alu_diff),
    .ge_o   (alu_ge)
  );

  tssva_period u_period (
    .clk_i     (clk_i),
    .divider_i (div_q),
    .period_o  (period)
  );

  tssva_ram #(
    .Width (PERIOD_W),
    .Depth (StepDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (a_q[AW-1:0]),
    .wdata_i (period),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_raddr = vptr_q[v_q];

  // --------------------------------------------------------------------------
  // Shared unit operand select
  // --------------------------------------------------------------------------
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_q)
      ST_LD_MOD, ST_PL_MOD: begin
        alu_a = a_q;
        alu_b = dsh_q;
      end
      ST_PL_REM: begin
        alu_a = AluW'(vlen_q[v_q]);
        alu_b = AluW'(vpos_q[v_q]);
      end
      ST_PL_CMP: begin
        alu_a = AluW'(rem_q);
        alu_b = AluW'(best_q);
      end
      ST_TK_SAT, ST_TK_CHK: begin
        alu_a = AluW'(acc_q);
        alu_b = AluW'(iv);
      end
      ST_V_CHK: begin
        alu_a = AluW'(vpos_q[v_q]);
        alu_b = AluW'(vlen_q[v_q]);
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (kind_e'(kind_i))
            KIND_LOAD: state_d = ST_LD_MOD;
            KIND_PLAY: state_d = (effect_length_i != '0) ? ST_PL_MOD : ST_IDLE;
            KIND_TICK: state_d = ST_TK_SAT;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_LD_MOD: if (k_q == '0) state_d = ST_LD_WR;
      ST_LD_WR:  state_d = ST_IDLE;
      ST_PL_MOD: if (k_q == '0) state_d = ST_PL_REM;
      ST_PL_REM: state_d = act_q[v_q] ? ST_PL_CMP : ST_PL_SET;
      ST_PL_CMP: state_d = vlast ? ST_PL_SET : ST_PL_REM;
      ST_PL_SET: state_d = ST_IDLE;
      ST_TK_SAT: state_d = ST_TK_CHK;
      ST_TK_CHK: state_d = alu_ge ? ST_V_CHK : ST_TK_END;
      ST_V_CHK: begin
        if (act_q[v_q] && !alu_ge) begin
          state_d = ST_V_DATA;
        end else begin
          state_d = vlast ? ST_TK_CHK : ST_V_CHK;
        end
      end
      ST_V_DATA: begin
        if (ram_rdata != '0) begin
          state_d = ST_V_HI;
        end else begin
          state_d = vlast ? ST_TK_CHK : ST_V_CHK;
        end
      end
      ST_V_HI:   state_d = ST_V_VOL;
      ST_V_VOL:  state_d = vlast ? ST_TK_CHK : ST_V_CHK;
      ST_TK_END: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath controls and register writes
  // --------------------------------------------------------------------------
  always_comb begin
    acc_d    = acc_q;
    v_d      = v_q;
    k_d      = k_q;
    a_d      = a_q;
    dsh_d    = dsh_q;
    div_d    = div_q;
    len_in_d = len_in_q;
    rem_d    = rem_q;
    best_d   = best_q;
    pick_d   = pick_q;
    act_d    = act_q;
    vlen_d   = vlen_q;
    vpos_d   = vpos_q;
    vptr_d   = vptr_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    emit_vld = 1'b0;
    emit_reg = '0;
    emit_val = '0;
    tick_end = 1'b0;

    case (state_q)
      ST_IDLE: begin
        // capture the command beat
        if (start) begin
          a_d      = AluW'(address_i);
          div_d    = divider_i;
          len_in_d = effect_length_i;
          k_d      = MOD_CNT_W'(MOD_STEPS - 1);
          dsh_d    = DshInit;
          v_d      = '0;
        end
      end
      ST_LD_MOD, ST_PL_MOD: begin
        // one restoring step of address reduction
        if (alu_ge) a_d = alu_diff;
        dsh_d = dsh_q >> 1;
        k_d   = k_q - MOD_CNT_W'(1);
      end
      ST_LD_WR: ram_we = 1'b1;
      ST_PL_REM: begin
        if (!act_q[v_q]) begin
          pick_d = v_q;
        end else begin
          rem_d = alu_diff[LEN_W-1:0];
        end
      end
      ST_PL_CMP: begin
        // fewest steps left wins, ties keep the lower voice
        if (v_q == '0 || !alu_ge) begin
          pick_d = v_q;
          best_d = rem_q;
        end
        if (!vlast) v_d = v_q + VIdxW'(1);
      end
      ST_PL_SET: begin
        act_d[pick_q]  = 1'b1;
        vlen_d[pick_q] = len_in_q;
        vpos_d[pick_q] = '0;
        vptr_d[pick_q] = a_q[AW-1:0];
      end
      ST_TK_SAT: begin
        // saturate a stale accumulator, then add the frame time
        acc_d = (alu_ge ? ({1'b0, iv} - ACC_W'(1)) : acc_q) + ACC_W'(inc_q);
      end
      ST_TK_CHK: begin
        if (alu_ge) begin
          acc_d = alu_diff[ACC_W-1:0];
          v_d   = '0;
        end
      end
      ST_V_CHK: begin
        if (act_q[v_q] && alu_ge) begin
          // effect done: mute and free
          act_d[v_q] = 1'b0;
          emit_vld   = 1'b1;
          emit_reg   = CHIP_VOL_BASE + CHIP_W'(v_q);
          emit_val   = '0;
        end else if (act_q[v_q]) begin
          ram_re       = 1'b1;
          vpos_d[v_q]  = vpos_q[v_q] + LEN_W'(1);
          vptr_d[v_q]  = (vptr_q[v_q] == PtrLast) ? '0 : vptr_q[v_q] + AW'(1);
        end
        if (!(act_q[v_q] && !alu_ge) && !vlast) v_d = v_q + VIdxW'(1);
      end
      ST_V_DATA: begin
        emit_vld = 1'b1;
        if (ram_rdata == '0) begin
          emit_reg = CHIP_VOL_BASE + CHIP_W'(v_q);
          emit_val = '0;
          if (!vlast) v_d = v_q + VIdxW'(1);
        end else begin
          emit_reg = CHIP_W'({v_q, 1'b0});
          emit_val = ram_rdata[VAL_W-1:0];
        end
      end
      ST_V_HI: begin
        emit_vld = 1'b1;
        emit_reg = CHIP_W'({v_q, 1'b1});
        emit_val = VAL_W'(ram_rdata[PERIOD_W-1:VAL_W]);
      end
      ST_V_VOL: begin
        emit_vld = 1'b1;
        emit_reg = CHIP_VOL_BASE + CHIP_W'(v_q);
        emit_val = VAL_W'(vol_q);
        if (!vlast) v_d = v_q + VIdxW'(1);
      end
      ST_TK_END: tick_end = 1'b1;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result staging: one write is held back so the final one can carry last
  // --------------------------------------------------------------------------
  always_comb begin
    pend_vld_d = pend_vld_q;
    pend_reg_d = pend_reg_q;
    pend_val_d = pend_val_q;
    out_vld_d  = 1'b0;
    out_last_d = 1'b0;
    out_reg_d  = out_reg_q;
    out_val_d  = out_val_q;
    if (emit_vld) begin
      if (pend_vld_q) begin
        out_vld_d = 1'b1;
        out_reg_d = pend_reg_q;
        out_val_d = pend_val_q;
      end
      pend_vld_d = 1'b1;
      pend_reg_d = emit_reg;
      pend_val_d = emit_val;
    end else if (tick_end && pend_vld_q) begin
      out_vld_d  = 1'b1;
      out_last_d = 1'b1;
      out_reg_d  = pend_reg_q;
      out_val_d  = pend_val_q;
      pend_vld_d = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      acc_q      <= '0;
      v_q        <= '0;
      k_q        <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
      for (int i = 0; i < VoiceCount; i++) begin
        act_q[i] <= 1'b0;
      end
    end else begin
      state_q    <= state_d;
      acc_q      <= acc_d;
      v_q        <= v_d;
      k_q        <= k_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      out_last_q <= out_last_d;
      act_q      <= act_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    dsh_q      <= dsh_d;
    div_q      <= div_d;
    len_in_q   <= len_in_d;
    rem_q      <= rem_d;
    best_q     <= best_d;
    pick_q     <= pick_d;
    vlen_q     <= vlen_d;
    vpos_q     <= vpos_d;
    vptr_q     <= vptr_d;
    pend_reg_q <= pend_reg_d;
    pend_val_q <= pend_val_d;
    out_reg_q  <= out_reg_d;
    out_val_q  <= out_val_d;
  end

  assign result_strobe_o = out_vld_q;
  assign last_o          = out_last_q;
  assign chip_register_o = out_reg_q;
  assign chip_value_o    = out_val_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a result beat only follows a cycle of tick work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(state_q != ST_IDLE))
    else $error("result beat without tick work");

  // last is only flagged on a real result beat
  a_last_on_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_strobe_o)
    else $error("last without result beat");

  // the held-back write is always flushed before returning to idle
  a_pend_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_vld_q)
    else $error("pending write left after tick");

  // accumulator stays below 32 between items (the largest step interval is 31)
  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (acc_q < ACC_W'(32)))
    else $error("accumulator out of range");

  // the store is never read and written in the same cycle
  a_ram_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store read and write collide");

endmodule

[hw/rtl/tssva_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data that holds while
// no read is issued.
// ----------------------------------------------------------------------------
module tssva_ram #(
  parameter int Width = 12,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/tssva_alu.sv]
// ----------------------------------------------------------------------------
// Shared compare / subtract unit
// Gives a - b and the unsigned a >= b flag; the sequencer's address
// reduction, remaining-step, accumulator and effect-end compares share it.
// ----------------------------------------------------------------------------
module tssva_alu #(
  parameter int Width = 22
) (
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  output logic [Width-1:0] diff_o,
  output logic             ge_o
);

  logic [Width:0] full;

  // Borrow of the extended subtract is the less-than flag
  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[Width-1:0];
  assign ge_o   = ~full[Width];

endmodule

[hw/rtl/tssva_period.sv]
// ----------------------------------------------------------------------------
// Divider to period converter
// Scales a timer divider by 6866/65536 and clamps to a 12-bit period; a
// zero divider gives a silent (zero) period. Registered output.
// ----------------------------------------------------------------------------
module tssva_period
  import tssva_pkg::*;
(
  input  logic                clk_i,
  input  logic [DIV_W-1:0]    divider_i,
  output logic [PERIOD_W-1:0] period_o
);

  logic [PROD_W-1:0]   prod;
  logic [QUO_W-1:0]    quo;
  logic [PERIOD_W-1:0] period_d;
  logic [PERIOD_W-1:0] period_q;

  // Scale and clamp
  assign prod = PROD_W'(divider_i) * PROD_W'(PERIOD_SCALE);
  assign quo  = prod[PROD_W-1:16];

  always_comb begin
    if (divider_i == '0) begin
      period_d = '0;
    end else if (quo == '0) begin
      period_d = PERIOD_W'(1);
    end else if (quo > QUO_W'(PERIOD_MAX)) begin
      period_d = PERIOD_MAX;
    end else begin
      period_d = quo[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    period_q <= period_d;
  end

  assign period_o = period_q;

endmodule

[tb/tb_tone_step_sequencer_voice_alloc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the three-voice tone step sequencer
// Drives load, play, tick and unknown commands through the start/busy
// handshake and programs the three registers while the block is idle. A
// model of the store, the voices and the time accumulator predicts every
// chip register write, and each strobed write is checked in order.
// ----------------------------------------------------------------------------
module tb_tone_step_sequencer_voice_alloc;
  import tssva_pkg::*;

  localparam int NUM_VOICES     = VOICE_COUNT_DEF;
  localparam int STORE_DEPTH    = STEP_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_PAD      = 64;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_ITEMS    = 38;

  // Kind code outside the defined set; the block must ignore it
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [CHIP_W-1:0] chip_reg;
    logic [VAL_W-1:0]  value;
    logic              last;
  } chip_write_t;

  // DUT ports
  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [KIND_W-1:0]     kind_i;
  logic [ADDR_W-1:0]     address_i;
  logic [DIV_W-1:0]      divider_i;
  logic [LEN_W-1:0]      effect_length_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  result_strobe_o;
  logic [CHIP_W-1:0]     chip_register_o;
  logic [VAL_W-1:0]      chip_value_o;
  logic                  last_o;

  tone_step_sequencer_voice_alloc dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .address_i       (address_i),
    .divider_i       (divider_i),
    .effect_length_i (effect_length_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_strobe_o (result_strobe_o),
    .chip_register_o (chip_register_o),
    .chip_value_o    (chip_value_o),
    .last_o          (last_o)
  );

  // Sequencer model state
  logic [PERIOD_W-1:0] period_mem [STORE_DEPTH];
  logic                voice_on   [NUM_VOICES];
  logic [ADDR_W-1:0]   voice_addr [NUM_VOICES];
  logic [LEN_W-1:0]    voice_len  [NUM_VOICES];
  logic [LEN_W-1:0]    voice_pos  [NUM_VOICES];
  logic [ACC_W-1:0]    acc_model;
  logic [INC_W-1:0]    tick_inc_cfg;
  logic [IV_W-1:0]     step_iv_cfg;
  logic [VOL_W-1:0]    volume_cfg;

  // Chip writes still to come, oldest first
  chip_write_t pending_writes_q [$];

  int idle_pct;
  int n_loads, n_plays, n_ticks, n_ignored, n_writes_seen, n_settings;
  int n_fail, n_reported;
  int quiet_cycles;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  function automatic logic [PERIOD_W-1:0] divider_to_period(input logic [DIV_W-1:0] div);
    int unsigned p;
    if (div == '0) return '0;
    p = (32'(div) * 32'(PERIOD_SCALE)) >> 16;
    if (p < 1) p = 1;
    if (p > 32'(PERIOD_MAX)) p = 32'(PERIOD_MAX);
    return p[PERIOD_W-1:0];
  endfunction

  task automatic push_chip_write(input logic [CHIP_W-1:0] r, input logic [VAL_W-1:0] v);
    chip_write_t w;
    w.chip_reg = r;
    w.value    = v;
    w.last     = 1'b0;
    pending_writes_q.push_back(w);
  endtask

  // First idle voice, else the busy voice with the fewest steps left
  task automatic allocate_voice(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
    int pick, best, left;
    pick = 0;
    best = 0;
    if (len == '0) return;
    for (int v = 0; v < NUM_VOICES; v++) begin
      if (!voice_on[v]) begin
        pick = v;
        break;
      end
      left = int'(voice_len[v]) - int'(voice_pos[v]);
      if (v == 0 || left < best) begin
        pick = v;
        best = left;
      end
    end
    voice_addr[pick] = addr;
    voice_len[pick]  = len;
    voice_pos[pick]  = '0;
    voice_on[pick]   = 1'b1;
  endtask

  task automatic step_voices_for_tick();
    int iv, acc, first, idx;
    logic [PERIOD_W-1:0] period;
    first = pending_writes_q.size();
    iv = (step_iv_cfg < MIN_INTERVAL) ? int'(MIN_INTERVAL) : int'(step_iv_cfg);
    acc = int'(acc_model);
    if (acc >= iv) acc = iv - 1;
    acc += int'(tick_inc_cfg);
    while (acc >= iv) begin
      acc -= iv;
      for (int v = 0; v < NUM_VOICES; v++) begin
        if (!voice_on[v]) continue;
        if (voice_pos[v] >= voice_len[v]) begin
          // effect done: mute and free
          voice_on[v] = 1'b0;
          push_chip_write(CHIP_VOL_BASE + CHIP_W'(v), '0);
          continue;
        end
        idx = (int'(voice_addr[v]) + int'(voice_pos[v])) % STORE_DEPTH;
        period = period_mem[idx];
        voice_pos[v] = voice_pos[v] + 1'b1;
        if (period == '0) begin
          push_chip_write(CHIP_VOL_BASE + CHIP_W'(v), '0);
        end else begin
          push_chip_write(CHIP_W'(2 * v), period[7:0]);
          push_chip_write(CHIP_W'(2 * v + 1), {4'b0, period[11:8]});
          push_chip_write(CHIP_VOL_BASE + CHIP_W'(v), {4'b0, volume_cfg});
        end
      end
    end
    acc_model = ACC_W'(acc);
    if (pending_writes_q.size() > first)
      pending_writes_q[pending_writes_q.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Sends one command beat; start stays high on return until the next negedge
  task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                          input logic [DIV_W-1:0] div, input logic [LEN_W-1:0] len);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 8) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      while (busy !== 1'b0) @(negedge clk_i);
      repeat (gap) @(negedge clk_i);
    end
    start           <= 1'b1;
    kind_i          <= kind;
    address_i       <= addr;
    divider_i       <= div;
    effect_length_i <= len;
    do @(posedge clk_i); while (busy !== 1'b0);
    case (kind)
      KIND_LOAD: begin
        period_mem[int'(addr) % STORE_DEPTH] = divider_to_period(div);
        n_loads++;
      end
      KIND_PLAY: begin
        allocate_voice(addr, len);
        n_plays++;
      end
      KIND_TICK: begin
        step_voices_for_tick();
        n_ticks++;
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic send_tick();
    send_cmd(KIND_TICK, ADDR_W'($urandom), DIV_W'($urandom), LEN_W'($urandom));
  endtask

  task automatic send_load(input logic [ADDR_W-1:0] addr, input logic [DIV_W-1:0] div);
    send_cmd(KIND_LOAD, addr, div, LEN_W'($urandom));
  endtask

  task automatic send_play(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
    send_cmd(KIND_PLAY, addr, DIV_W'($urandom), len);
  endtask

  // Drop start, wait for every write and the block to go idle, then a margin
  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_writes_q.size() != 0 || busy !== 1'b0) @(negedge clk_i);
    repeat (DRAIN_PAD) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_TICK_INC: tick_inc_cfg = data[INC_W-1:0];
      CFG_STEP_IV:  step_iv_cfg  = data[IV_W-1:0];
      CFG_VOLUME:   volume_cfg   = data[VOL_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_setting(input int inc, input int iv, input int vol);
    cfg_write(CFG_TICK_INC, CFG_DATA_W'(inc));
    cfg_write(CFG_STEP_IV, CFG_DATA_W'(iv));
    cfg_write(CFG_VOLUME, CFG_DATA_W'(vol));
    n_settings++;
  endtask

  // Divider with weight on zero, low clamp and high clamp
  function automatic logic [DIV_W-1:0] pick_divider();
    int r;
    r = $urandom_range(99);
    if (r < 12) return '0;
    if (r < 22) return DIV_W'($urandom_range(1, 9));
    if (r < 42) return DIV_W'($urandom_range(39088, 65535));
    return DIV_W'($urandom);
  endfunction

  // Mostly short effects so voices finish and get reused
  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 70) return LEN_W'($urandom_range(1, 16));
    if (r < 90) return LEN_W'($urandom_range(17, 300));
    return LEN_W'($urandom_range(301, 8191));
  endfunction

  function automatic int pick_reg_value(input int lo, input int hi);
    int r;
    r = $urandom_range(99);
    if (r < 25) return lo;
    if (r < 50) return hi;
    return $urandom_range(lo, hi);
  endfunction

  task automatic send_random_item();
    int r;
    r = $urandom_range(99);
    if (r < 55) send_tick();
    else if (r < 80) send_play(ADDR_W'($urandom), pick_length());
    else if (r < 95) send_load(ADDR_W'($urandom), pick_divider());
    else send_cmd(KIND_UNKNOWN, ADDR_W'($urandom), DIV_W'($urandom), LEN_W'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every entry gets a period so no effect ever reads an unwritten one
  task automatic test_store_fill();
    idle_pct = 0;
    send_tick(); // no voice yet: no writes
    for (int a = 0; a < STORE_DEPTH; a++) send_load(ADDR_W'(a), pick_divider());
  endtask

  task automatic test_load_play_tick();
    send_load(12'd0, 16'd0);          // silent
    send_load(12'd4095, 16'hFFFF);    // clamps to 0xFFF
    send_load(12'd1, 16'd1);          // clamps to 1
    send_load(12'd2, 16'd39088);
    send_load(12'd3, 16'd20000);
    send_play(12'd4094, 13'd4);       // wraps past the top of the store
    send_play(12'd5, 13'd0);          // ignored
    send_cmd(KIND_UNKNOWN, 12'hFFF, 16'hFFFF, 13'h1FFF);
    send_play(12'd0, 13'd2);
    send_play(12'd10, 13'd3);
    repeat (3) send_tick();
    send_play(12'd20, 13'd5);
    send_play(12'd30, 13'd5);
    send_play(12'd40, 13'd5);         // equal lengths: steal goes to the lowest voice
    send_play(12'd50, 13'd4096);
    send_play(12'd60, 13'h1FFF);      // length above the nominal range
    repeat (4) send_tick();
  endtask

  task automatic test_increment_extremes();
    wait_idle();
    apply_setting(0, 8, 15);          // zero increment: ticks never step
    send_play(12'd100, 13'd3);
    repeat (2) send_tick();
    wait_idle();
    apply_setting(31, 8, 15);         // four steps per tick
    send_play(12'd200, 13'd6);
    send_play(12'd300, 13'd2);
    repeat (3) send_tick();
    wait_idle();
    apply_setting(31, 0, 0);          // interval below the minimum
    send_play(12'd310, 13'd9);
    repeat (2) send_tick();
  endtask

  task automatic test_interval_lowered();
    wait_idle();
    apply_setting(30, 31, 7);
    send_play(12'd400, 13'd40);
    send_play(12'd500, 13'd40);
    send_play(12'd600, 13'd40);
    for (int i = 0; i < 4 && acc_model < 6'd20; i++) send_tick();
    wait_idle();
    apply_setting(30, 8, 1);          // accumulator now saturates to interval-1
    repeat (2) send_tick();
    wait_idle();
    apply_setting(1, 5, 12);
    repeat (2) send_tick();
  endtask

  task automatic test_random_traffic();
    int idle_plan [3] = '{0, 60, 29};
    foreach (idle_plan[p]) begin
      repeat (2) begin
        wait_idle();
        apply_setting(($urandom_range(9) == 0) ? 0 : pick_reg_value(1, 31),
                      ($urandom_range(9) == 0) ? $urandom_range(0, 7) : pick_reg_value(8, 31),
                      pick_reg_value(0, 15));
        idle_pct = idle_plan[p];
        repeat (PHASE_ITEMS) send_random_item();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic note_failure(input string what, input chip_write_t want,
                              input chip_write_t got);
    n_fail++;
    if (n_reported < MAX_REPORTS) begin
      n_reported++;
      $display("%0t: %s: expected reg %0d val 0x%02h last %0b, got reg %0d val 0x%02h last %0b",
               $realtime, what, want.chip_reg, want.value, want.last,
               got.chip_reg, got.value, got.last);
    end
  endtask

  always @(posedge clk_i) begin : chk_chip_write
    chip_write_t got;
    chip_write_t want;
    if (rst_ni && result_strobe_o) begin
      got.chip_reg = chip_register_o;
      got.value    = chip_value_o;
      got.last     = last_o;
      if (pending_writes_q.size() == 0) begin
        want = '0;
        note_failure("unexpected write", want, got);
      end else begin
        want = pending_writes_q.pop_front();
        n_writes_seen++;
        if (got !== want) note_failure("write mismatch", want, got);
      end
    end
  end

  // Watchdog: cycles with no command beat and no result beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_strobe_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d writes outstanding",
                 quiet_cycles, pending_writes_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    kind_i          = KIND_LOAD;
    address_i       = '0;
    divider_i       = '0;
    effect_length_i = '0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_TICK_INC;
    cfg_data_i      = '0;
    quiet_cycles    = 0;
    idle_pct        = 0;
    n_loads = 0; n_plays = 0; n_ticks = 0; n_ignored = 0;
    n_writes_seen = 0; n_settings = 0; n_fail = 0; n_reported = 0;

    // model reset
    for (int v = 0; v < NUM_VOICES; v++) begin
      voice_on[v]   = 1'b0;
      voice_addr[v] = '0;
      voice_len[v]  = '0;
      voice_pos[v]  = '0;
    end
    for (int a = 0; a < STORE_DEPTH; a++) period_mem[a] = '0;
    acc_model    = '0;
    tick_inc_cfg = TICK_INC_RST;
    step_iv_cfg  = STEP_IV_RST;
    volume_cfg   = VOLUME_RST;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_store_fill();
    test_load_play_tick();
    test_increment_extremes();
    test_interval_lowered();
    test_random_traffic();
    wait_idle();

    $display("Run: %0d loads, %0d plays, %0d ticks, %0d unknown-kind commands",
             n_loads, n_plays, n_ticks, n_ignored);
    $display("Run: %0d chip writes checked over %0d register settings, %0d failures",
             n_writes_seen, n_settings, n_fail);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
